// ----- rtl/core/tccw_pkg.sv -----
// tccw_pkg: shared constants, request and character codes, and the
// command and status structs between the controller and the datapath
// no dependencies
package tccw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(CELLS);

    // word field widths
    localparam int REQ_W      = 3;
    localparam int CHAR_W     = 8;
    localparam int IN_ROW_W   = 6;
    localparam int IN_COL_W   = 7;
    localparam int COLOR_W    = 8;
    localparam int OUT_ROW_W  = 5;
    localparam int OUT_COL_W  = 7;
    localparam int HW_W       = 13;
    localparam int CELL_W     = CHAR_W + COLOR_W;
    localparam int S_TDATA_W  = 32;
    localparam int OUT_BITS   = OUT_ROW_W + OUT_COL_W + HW_W + CHAR_W + 1;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUT        = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DRAW       = 3'd1;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SET_CURSOR = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;

    // control characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_HIDDEN = 1'd1;

    localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'd7;
    localparam logic [HW_W-1:0]    HW_CURSOR_HIDDEN = HW_W'(COLUMNS * COLUMNS);

    typedef struct packed {
        logic load_req;
        logic exec;
        logic copy_step;
        logic blank_step;
        logic out_load;
    } tccw_cmd_t;

    typedef struct packed {
        logic needs_read;
        logic needs_scroll;
        logic needs_clear;
        logic copy_last;
        logic blank_last;
        logic out_free;
    } tccw_status_t;

endpackage

// ----- rtl/core/tccw_ctrl.sv -----
// tccw_ctrl: request sequencer for the console engine
// depends on tccw_pkg (command and status structs)
module tccw_ctrl
    import tccw_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  tccw_status_t status,
    output tccw_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_COPY,
        ST_BLANK,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (status.needs_read) begin
                    state_next = ST_RDWAIT;
                end else if (status.needs_scroll) begin
                    state_next = ST_COPY;
                end else if (status.needs_clear) begin
                    state_next = ST_BLANK;
                end else if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_RDWAIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_COPY: begin
                cmd.copy_step = 1'b1;
                if (status.copy_last) begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK: begin
                cmd.blank_step = 1'b1;
                if (status.blank_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/tccw_datapath.sv -----
// tccw_datapath: request registers, cursor, config registers, screen
// memory with sweep counter, and the output register
// depends on tccw_pkg (geometry, codes, command and status structs)
module tccw_datapath
    import tccw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [REQ_W-1:0]      s_tuser,
    input  tccw_cmd_t             cmd,
    output tccw_status_t          status,
    output logic                  m_tvalid,
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tready
);

    logic [REQ_W-1:0]     req_type_reg;
    logic [CHAR_W-1:0]    req_char_reg;
    logic [IN_ROW_W-1:0]  req_row_reg;
    logic [IN_COL_W-1:0]  req_col_reg;
    logic [COLOR_W-1:0]   req_color_reg;

    logic [COLOR_W-1:0]   text_color_reg;
    logic                 cursor_hidden_reg;

    logic [ROW_W-1:0]     cur_row_reg;
    logic [ROW_W-1:0]     cur_row_next;
    logic [COL_W-1:0]     cur_col_reg;
    logic [COL_W-1:0]     cur_col_next;

    logic [ADDR_W-1:0]    sweep_cnt_reg;
    logic [ADDR_W-1:0]    sweep_cnt_next;

    logic [CELL_W-1:0]    screen_mem [CELLS];
    logic [CELL_W-1:0]    rd_data_reg;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [CELL_W-1:0]    wr_data;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    logic                 in_range;
    logic [ADDR_W-1:0]    req_addr;
    logic [ADDR_W-1:0]    cur_addr;
    logic [ADDR_W-1:0]    next_addr;
    logic                 is_nl;
    logic                 is_cr;
    logic                 is_bs;
    logic                 row_last;
    logic                 col_last;
    logic [CELL_W-1:0]    blank_cell;
    logic [CHAR_W-1:0]    read_char;
    logic                 err;
    logic [HW_W-1:0]      hw_cursor;

    assign in_range  = (32'(req_row_reg) < ROWS) && (32'(req_col_reg) < COLUMNS);
    assign req_addr  = ADDR_W'(32'(req_row_reg) * COLUMNS + 32'(req_col_reg));
    assign cur_addr  = ADDR_W'(32'(cur_row_reg) * COLUMNS + 32'(cur_col_reg));
    assign next_addr = ADDR_W'(32'(cur_row_next) * COLUMNS + 32'(cur_col_next));
    assign is_nl     = (req_char_reg == CH_NEWLINE);
    assign is_cr     = (req_char_reg == CH_RETURN);
    assign is_bs     = (req_char_reg == CH_BACKSPACE);
    assign row_last  = (32'(cur_row_reg) == ROWS - 1);
    assign col_last  = (32'(cur_col_reg) == COLUMNS - 1);
    assign blank_cell = {text_color_reg, CH_BLANK};

    assign status.needs_read   = (req_type_reg == REQ_READ) && in_range;
    assign status.needs_scroll = (req_type_reg == REQ_PUT) && row_last &&
                                 (is_nl || (!is_cr && !is_bs && col_last));
    assign status.needs_clear  = (req_type_reg == REQ_CLEAR);
    assign status.copy_last    = (sweep_cnt_reg == ADDR_W'(CELLS - COLUMNS));
    assign status.blank_last   = (sweep_cnt_reg == ADDR_W'(CELLS - 1));
    assign status.out_free     = !m_tvalid_reg || m_tready;

    // cursor update, single-cell write and sweep address
    always_comb begin
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        sweep_cnt_next = sweep_cnt_reg;
        wr_en          = 1'b0;
        wr_addr        = sweep_cnt_reg;
        wr_data        = blank_cell;
        rd_en          = 1'b0;
        rd_addr        = req_addr;
        if (cmd.exec) begin
            sweep_cnt_next = '0;
            case (req_type_reg)
                REQ_PUT: begin
                    if (is_nl) begin
                        cur_col_next = '0;
                        if (!row_last) begin
                            cur_row_next = cur_row_reg + ROW_W'(1);
                        end
                    end else if (is_cr) begin
                        cur_col_next = '0;
                    end else if (is_bs) begin
                        if (cur_col_reg != '0) begin
                            cur_col_next = cur_col_reg - COL_W'(1);
                            wr_en        = 1'b1;
                            wr_addr      = cur_addr - ADDR_W'(1);
                        end
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = cur_addr;
                        wr_data = {text_color_reg, req_char_reg};
                        if (col_last) begin
                            cur_col_next = '0;
                            if (!row_last) begin
                                cur_row_next = cur_row_reg + ROW_W'(1);
                            end
                        end else begin
                            cur_col_next = cur_col_reg + COL_W'(1);
                        end
                    end
                end
                REQ_DRAW: begin
                    if (in_range) begin
                        wr_en   = 1'b1;
                        wr_addr = req_addr;
                        wr_data = {req_color_reg, req_char_reg};
                    end
                end
                REQ_READ: begin
                    rd_en = in_range;
                end
                REQ_SET_CURSOR: begin
                    if (in_range) begin
                        cur_row_next = ROW_W'(req_row_reg);
                        cur_col_next = COL_W'(req_col_reg);
                    end
                end
                REQ_CLEAR: begin
                    cur_row_next = '0;
                    cur_col_next = '0;
                end
                default: begin
                end
            endcase
        end else if (cmd.copy_step) begin
            // read one line ahead, write back the word fetched last cycle
            if (!status.copy_last) begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(32'(sweep_cnt_reg) + COLUMNS);
            end
            if (sweep_cnt_reg != '0) begin
                wr_en   = 1'b1;
                wr_addr = sweep_cnt_reg - ADDR_W'(1);
                wr_data = rd_data_reg;
            end
            sweep_cnt_next = status.copy_last ? ADDR_W'(CELLS - COLUMNS)
                                              : sweep_cnt_reg + ADDR_W'(1);
        end else if (cmd.blank_step) begin
            wr_en          = 1'b1;
            sweep_cnt_next = sweep_cnt_reg + ADDR_W'(1);
        end
    end

    // result word
    always_comb begin
        read_char = status.needs_read ? rd_data_reg[CHAR_W-1:0] : '0;
        err       = (req_type_reg inside {REQ_DRAW, REQ_READ, REQ_SET_CURSOR}) && !in_range;
        hw_cursor = cursor_hidden_reg ? HW_CURSOR_HIDDEN : HW_W'(next_addr);
        m_tdata_next = {(M_TDATA_W - OUT_BITS)'(0), err, read_char, hw_cursor,
                        OUT_COL_W'(cur_col_next), OUT_ROW_W'(cur_row_next)};
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            screen_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= screen_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_type_reg  <= s_tuser;
            req_char_reg  <= s_tdata[7:0];
            req_row_reg   <= s_tdata[13:8];
            req_col_reg   <= s_tdata[20:14];
            req_color_reg <= s_tdata[28:21];
        end
        if (cmd.out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg    <= TEXT_COLOR_RESET;
            cursor_hidden_reg <= 1'b0;
            cur_row_reg       <= '0;
            cur_col_reg       <= '0;
            sweep_cnt_reg     <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_TEXT_COLOR:    text_color_reg    <= cfg_wr_data;
                    REG_CURSOR_HIDDEN: cursor_hidden_reg <= cfg_wr_data[0];
                    default: begin
                    end
                endcase
            end
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            sweep_cnt_reg <= sweep_cnt_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/core/text_console_cell_writer_core.sv -----
// text_console_cell_writer_core: character-cell console engine, top level
// depends on tccw_pkg, tccw_ctrl and tccw_datapath
//
// usage
//   s_ channel takes one request word; the request code rides on s_tuser,
//   the character, position and color on s_tdata
//   m_ channel returns exactly one result word per request: cursor after the
//   request, hardware cursor value, read character and range error flag
//   cfg_wr_* writes text_color (index 0) or cursor_hidden (index 1) in one
//   cycle; write only while no request is in flight
// latency and throughput
//   put byte, draw, set cursor and unused codes: 2 cycles per word
//   read cell: 3 cycles per word, set by the registered memory read port
//   scroll (newline on the last row, or print into the last cell):
//   3 + (CELLS - COLUMNS + 1) + COLUMNS cycles, one cell moved per cycle
//   clear screen: 3 + CELLS cycles, one cell blanked per cycle
//   one request is worked on at a time; s_tready is high only while idle
// reset
//   cursor goes home, text_color to 7, cursor_hidden to 0; the screen memory
//   is not cleared and holds garbage until cells are written or cleared
// stall
//   the result sits in an output register; a new request is taken while it
//   waits, and the engine holds its next result until m_tready frees the slot
module text_console_cell_writer_core
    import tccw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,

    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // char_code[7:0], row[13:8], col[20:14], cell_color[28:21], zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // req_type[2:0]
    input  logic [REQ_W-1:0]      s_tuser,

    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cursor_row[4:0], cursor_col[11:5], hw_cursor[24:12], read_char[32:25],
    // status[33], zero fill
    output logic [M_TDATA_W-1:0]  m_tdata
);

    tccw_cmd_t    cmd;
    tccw_status_t status;

    // sequencer: decides per request which datapath steps run
    tccw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // cursor, screen memory, config registers and result register
    tccw_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata),
        .m_tready     (m_tready)
    );

endmodule
